>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// The including scope must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define MMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/mma_pkg.sv
// Shared types, codes and the byte classifier of the MIDI message assembler.
// No dependencies.
package mma_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	localparam logic [7:0] SYSEX_START_BYTE = 8'hF0;
	localparam logic [7:0] SYSEX_END_BYTE   = 8'hF7;

	typedef enum logic [2:0] {
		CLS_DATA,
		CLS_SYSEX_START,
		CLS_SYSEX_END,
		CLS_SINGLE,
		CLS_STATUS1,
		CLS_STATUS2
	} cls_t;

	typedef enum logic [2:0] {
		KIND_SYSEX,
		KIND_SYSEX_END,
		KIND_REALTIME,
		KIND_MSG2,
		KIND_MSG3
	} kind_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] data;
	} q_entry_t;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		if (!b[7]) begin
			c = CLS_DATA;
		end else if (b == SYSEX_START_BYTE) begin
			c = CLS_SYSEX_START;
		end else if (b == SYSEX_END_BYTE) begin
			c = CLS_SYSEX_END;
		end else if (b == 8'hF4 || b == 8'hF5 || b == 8'hF6 || b >= 8'hF8) begin
			c = CLS_SINGLE;
		end else if (b[7:4] == 4'h8 || b[7:4] == 4'h9 || b[7:4] == 4'hA ||
			b[7:4] == 4'hB || b[7:4] == 4'hE || b == 8'hF2) begin
			c = CLS_STATUS2;
		end else begin
			c = CLS_STATUS1;
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/mma_front.sv
// Front end: takes input beats and tags each byte with its class.
// Depends on mma_pkg.
module mma_front (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               full,
	output logic               push,
	output mma_pkg::q_entry_t  push_entry
);

	assign s_tready        = !full;
	assign push            = s_tvalid && !full;
	assign push_entry.cls  = mma_pkg::classify(s_tdata);
	assign push_entry.data = s_tdata;

endmodule

>>> hw/rtl/mma_queue.sv
// Two-entry queue between the classifier and the message builder.
// Depends on mma_pkg.
module mma_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  mma_pkg::q_entry_t         push_entry,
	output logic                      full,
	input  logic                      pop,
	output logic                      q_valid,
	output mma_pkg::q_entry_t         head
);

	mma_pkg::q_entry_t                 slot_q [mma_pkg::QDEPTH];
	logic [mma_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [mma_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [mma_pkg::QCNT_W-1:0]        count_q;

	assign full    = (count_q == mma_pkg::QCNT_W'(mma_pkg::QDEPTH));
	assign q_valid = (count_q != '0);
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/mma_back.sv
// Back end: parse state machine that assembles messages and drives the output register.
// Depends on mma_pkg.
module mma_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mma_pkg::q_entry_t  head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,
	output logic [2:0]         m_tuser
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_SYSEX,
		M_ONE,
		M_TWO
	} mode_t;

	mode_t           mode_q, mode_d;
	logic [1:0]      fill_q, fill_d;
	logic [7:0]      held0_q, held1_q;
	logic            valid_q;
	mma_pkg::kind_t  kind_q, kind_d;
	logic [7:0]      b1_q, b2_q, b3_q;
	logic [7:0]      b1_d, b2_d, b3_d;
	logic            emit, we0, we1;
	logic [7:0]      byte_in;

	assign byte_in  = head.data;
	assign pop      = q_valid && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {b3_q, b2_q, b1_q};

	always_comb begin
		mode_d = mode_q;
		fill_d = fill_q;
		emit   = 1'b0;
		we0    = 1'b0;
		we1    = 1'b0;
		kind_d = mma_pkg::KIND_SYSEX;
		b1_d   = byte_in;
		b2_d   = 8'h00;
		b3_d   = 8'h00;
		if (mode_q == M_SYSEX) begin
			emit = 1'b1;
			if (head.cls == mma_pkg::CLS_SYSEX_END) begin
				// The end byte closes SysEx; the next byte is parsed as in idle.
				kind_d = mma_pkg::KIND_SYSEX_END;
				mode_d = M_IDLE;
				fill_d = 2'd0;
			end
		end else begin
			case (head.cls)
				mma_pkg::CLS_SYSEX_START: begin
					emit   = 1'b1;
					mode_d = M_SYSEX;
					fill_d = 2'd0;
				end
				mma_pkg::CLS_SYSEX_END: begin
				end
				mma_pkg::CLS_SINGLE: begin
					emit   = 1'b1;
					kind_d = mma_pkg::KIND_REALTIME;
				end
				mma_pkg::CLS_STATUS1: begin
					mode_d = M_ONE;
					fill_d = 2'd1;
					we0    = 1'b1;
				end
				mma_pkg::CLS_STATUS2: begin
					mode_d = M_TWO;
					fill_d = 2'd1;
					we0    = 1'b1;
				end
				mma_pkg::CLS_DATA: begin
					if (mode_q == M_ONE) begin
						if (fill_q == 2'd0) begin
							we0    = 1'b1;
							fill_d = 2'd1;
						end else begin
							emit   = 1'b1;
							kind_d = mma_pkg::KIND_MSG2;
							b1_d   = held0_q;
							b2_d   = byte_in;
							fill_d = 2'd0;
						end
					end else if (mode_q == M_TWO) begin
						if (fill_q == 2'd0) begin
							we0    = 1'b1;
							fill_d = 2'd1;
						end else if (fill_q == 2'd1) begin
							we1    = 1'b1;
							fill_d = 2'd2;
						end else begin
							emit   = 1'b1;
							kind_d = mma_pkg::KIND_MSG3;
							b1_d   = held0_q;
							b2_d   = held1_q;
							b3_d   = byte_in;
							fill_d = 2'd0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && we0) begin
			held0_q <= byte_in;
		end
		if (pop && we1) begin
			held1_q <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			fill_q  <= 2'd0;
			valid_q <= 1'b0;
			kind_q  <= mma_pkg::KIND_SYSEX;
			b1_q    <= 8'h00;
			b2_q    <= 8'h00;
			b3_q    <= 8'h00;
		end else begin
			if (pop) begin
				mode_q <= mode_d;
				fill_q <= fill_d;
			end
			if (pop && emit) begin
				valid_q <= 1'b1;
				kind_q  <= kind_d;
				b1_q    <= b1_d;
				b2_q    <= b2_d;
				b3_q    <= b3_d;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/midi_message_assembler.sv
// MIDI message assembler: one byte in per beat, at most one message out per byte.
// Path: an accepted byte is held in a queue slot, then popped by the parser, which registers any message it completes.
// Throughput: one byte per cycle while the output is not stalled; the queue pops one entry per cycle whenever the
// output register is empty or being taken.
// Reset (arst_n low, asynchronous): queue empty, parser idle, no output pending.
// Depends on mma_pkg, mma_front, mma_queue and mma_back.
module midi_message_assembler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte
	output logic [2:0]  m_tuser    // [2:0] kind
);

	logic               full;
	logic               push;
	logic               pop;
	logic               q_valid;
	mma_pkg::q_entry_t  push_entry;
	mma_pkg::q_entry_t  head;

	mma_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	mma_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	mma_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> hw/rtl/mma_checker.sv
// Port-level checker for the MIDI message assembler, bound to the top level.
// Depends on mma_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	logic        single_kind;
	logic        msg_kind;
	logic        end_kind;
	logic        out_stall;
	logic        upper_zero;
	logic        data_clean;
	logic        end_ok;
	logic [26:0] out_beat;

	assign single_kind = (m_tuser == 3'(mma_pkg::KIND_SYSEX)) ||
		(m_tuser == 3'(mma_pkg::KIND_SYSEX_END)) || (m_tuser == 3'(mma_pkg::KIND_REALTIME));
	assign msg_kind = (m_tuser == 3'(mma_pkg::KIND_MSG2)) || (m_tuser == 3'(mma_pkg::KIND_MSG3));
	assign end_kind   = (m_tuser == 3'(mma_pkg::KIND_SYSEX_END));
	assign out_stall  = m_tvalid && !m_tready;
	assign upper_zero = (m_tdata[23:8] == 16'h0000);
	assign data_clean = !m_tdata[15] && !m_tdata[23];
	assign end_ok     = (m_tdata[7:0] == mma_pkg::SYSEX_END_BYTE);
	assign out_beat   = {m_tuser, m_tdata};

	`MMA_ASSERT_NEXT(a_stall_hold, out_stall, m_tvalid && $stable(out_beat), "beat changed in stall")
	`MMA_ASSERT(a_kind_legal, m_tvalid |-> (single_kind || msg_kind), "illegal kind on output")
	`MMA_ASSERT(a_single_tail, (m_tvalid && single_kind) |-> upper_zero, "single beat has data")
	`MMA_ASSERT(a_msg_data, (m_tvalid && msg_kind) |-> data_clean, "data byte has status bit")
	`MMA_ASSERT(a_end_byte, (m_tvalid && end_kind) |-> end_ok, "end beat is not the end byte")

endmodule

bind midi_message_assembler mma_checker u_mma_checker (.*);
